[hdl/assert_macros.svh]
// assertion macros used by the rtl top level of the allocator
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled during reset
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPL(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/bffa_pkg.sv]
// shared types, constants and helper functions of the first-fit bitmap allocator
// no dependencies
package bffa_pkg;

    // pool sizes and field widths
    localparam int INODE_COUNT = 256;
    localparam int BLOCK_COUNT = 2048;
    localparam int IDX_W       = 11;
    localparam int DS_W        = 11;
    localparam int STATUS_W    = 2;
    localparam int DS_RESET    = 100;

    // bitmap word organisation, inode rows first, block rows after them
    localparam int WORD_W      = 32;
    localparam int WORD_AW     = $clog2(WORD_W);
    localparam int INODE_WORDS = (INODE_COUNT + WORD_W - 1) / WORD_W;
    localparam int BLOCK_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int MAP_WORDS   = INODE_WORDS + BLOCK_WORDS;
    localparam int MAP_AW      = $clog2(MAP_WORDS);

    // counter widths and compare width for range checks
    localparam int INODE_CNT_W = $clog2(INODE_COUNT + 1);
    localparam int BLOCK_CNT_W = $clog2(BLOCK_COUNT + 1);
    localparam int LIM_W       = 17;
    localparam int BLOCK_CNT_RESET = (DS_RESET < BLOCK_COUNT) ? BLOCK_COUNT - DS_RESET : 0;

    // request codes
    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_FREE    = 1'b1;
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef logic [WORD_W-1:0] t_word;

    // memory request from the sequencer
    typedef struct packed {
        logic              we;
        logic [MAP_AW-1:0] waddr;
        t_word             wdata;
        logic              re;
        logic [MAP_AW-1:0] raddr;
    } t_ram_req;

    // one result beat
    typedef struct packed {
        logic [IDX_W-1:0] granted_index;
        t_status          status;
        logic [IDX_W-1:0] free_count;
    } t_result;

    // lowest clear bit of a word
    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] pos;
    } t_zero;

    // bits past the end of a pool in its last word read as used
    function automatic t_word tail_mask(input int count);
        t_word m;
        int    rem;
        m   = '0;
        rem = count % WORD_W;
        for (int b = 0; b < WORD_W; b++) begin
            if (rem != 0 && b >= rem) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam t_word INODE_TAIL = tail_mask(INODE_COUNT);
    localparam t_word BLOCK_TAIL = tail_mask(BLOCK_COUNT);

    // bits below the start offset read as used
    function automatic t_word below_mask(input logic [WORD_AW-1:0] off);
        t_word m;
        for (int b = 0; b < WORD_W; b++) begin
            m[b] = (b < int'(off));
        end
        return m;
    endfunction

    // priority encoder for the lowest zero bit
    function automatic t_zero lowest_zero(input t_word w);
        t_zero z;
        z = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!w[b]) begin
                z.found = 1'b1;
                z.pos   = WORD_AW'(b);
            end
        end
        return z;
    endfunction

endpackage

[hdl/bitmap_first_fit_allocator.sv]
// First-fit allocator over an inode bitmap and a block bitmap, kept as 32-bit words in one
// word memory. An allocate request scans one word per cycle through a single lowest-zero
// search unit until it finds a clear bit or has read the last word of its pool, at most 8
// words for inodes and 64 for blocks. The block is not ready from an accepted request
// until its result beat has moved into the output register. Per-row valid bits stand in
// for clearing the memory, so there is no clearing pass after reset or after a data_start
// write.
// top level; depends on bffa_pkg, bffa_ram, bffa_ctrl and assert_macros.svh
`include "assert_macros.svh"

module bitmap_first_fit_allocator
    import bffa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [DS_W-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic                i_pool,
    input  logic [IDX_W-1:0]    i_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [IDX_W-1:0]    o_granted_index,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_free_count
);

    t_ram_req ram_req;
    t_word    rdata;
    logic     res_valid;
    logic     res_ready;
    t_result  res;
    logic     r_out_valid;
    t_result  r_out;

    // bitmap word memory
    bffa_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    // scan sequencer
    bffa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_pool      (i_pool),
        .i_index     (i_index),
        .o_ram       (ram_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register for the result beat
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_out.granted_index;
    assign o_status        = r_out.status;
    assign o_free_count    = r_out.free_count;

    // busy right after a request is taken
    `AST_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // only a successful allocate carries a nonzero index
    `AST_IMPL(a_grant_only_ok, i_clk, i_rst_n, r_out_valid && (r_out.status != ST_OK), r_out.granted_index == '0)
    // a full pool has a zero free counter
    `AST_IMPL(a_full_zero_count, i_clk, i_rst_n, r_out_valid && (r_out.status == ST_FULL), r_out.free_count == '0)

endmodule

[hdl/bffa_ram.sv]
// single-port-write, single-port-read word memory with registered read data
// no dependencies
module bffa_ram #(
    parameter int DEPTH = 72,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bffa_ctrl.sv]
// scan sequencer: walks bitmap words through the shared search unit, keeps counters,
// row valid bits and the data start register; depends on bffa_pkg
module bffa_ctrl
    import bffa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DS_W-1:0]  i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_func,
    input  logic             i_pool,
    input  logic [IDX_W-1:0] i_index,
    output t_ram_req         o_ram,
    input  t_word            i_rdata,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH
    } t_state;

    t_state                 r_state;
    logic                   r_func;
    logic                   r_pool;
    logic [MAP_AW-1:0]      r_row;
    logic [MAP_AW-1:0]      r_first_row;
    logic [MAP_AW-1:0]      r_last_row;
    logic [WORD_AW-1:0]     r_off;
    logic [MAP_WORDS-1:0]   r_valid;
    logic [INODE_CNT_W-1:0] r_inode_cnt;
    logic [BLOCK_CNT_W-1:0] r_block_cnt;
    logic [DS_W-1:0]        r_data_start;
    t_result                r_res;

    logic                   accept;
    logic [DS_W-1:0]        eff_start;
    logic [DS_W-1:0]        cfg_eff;
    logic [BLOCK_CNT_W-1:0] blk_reload;
    logic                   blk_empty;
    logic [MAP_AW-1:0]      start_row;
    logic [WORD_AW-1:0]     start_off;
    logic [MAP_AW-1:0]      idx_row;
    logic                   in_range;
    logic                   alloc_go;
    logic [IDX_W-1:0]       in_cnt;
    logic [IDX_W-1:0]       cur_cnt;
    logic [INODE_CNT_W-1:0] inode_dec;
    logic [INODE_CNT_W-1:0] inode_inc;
    logic [BLOCK_CNT_W-1:0] block_dec;
    logic [BLOCK_CNT_W-1:0] block_inc;
    t_word                  cur;
    t_word                  masked;
    t_word                  tail;
    t_zero                  lz;
    logic [MAP_AW-1:0]      wip;
    logic [IDX_W-1:0]       grant_idx;
    logic                   bit_set;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    // effective block range start, zero acts as one
    assign eff_start  = (r_data_start == '0) ? DS_W'(1) : r_data_start;
    assign cfg_eff    = (i_cfg_data == '0) ? DS_W'(1) : i_cfg_data;
    assign blk_empty  = !(LIM_W'(eff_start) < LIM_W'(BLOCK_COUNT));
    assign blk_reload = (LIM_W'(cfg_eff) < LIM_W'(BLOCK_COUNT))
                      ? BLOCK_CNT_W'(LIM_W'(BLOCK_COUNT) - LIM_W'(cfg_eff))
                      : '0;

    // first word and bit of a scan, and word of a free request
    always_comb begin
        if (i_pool == POOL_BLOCK) begin
            start_row = MAP_AW'(INODE_WORDS) + MAP_AW'(eff_start >> WORD_AW);
            start_off = eff_start[WORD_AW-1:0];
            idx_row   = MAP_AW'(INODE_WORDS) + MAP_AW'(i_index >> WORD_AW);
            in_range  = (LIM_W'(i_index) >= LIM_W'(eff_start))
                     && (LIM_W'(i_index) < LIM_W'(BLOCK_COUNT));
            in_cnt    = IDX_W'(r_block_cnt);
        end else begin
            start_row = '0;
            start_off = WORD_AW'(1);
            idx_row   = MAP_AW'(i_index >> WORD_AW);
            in_range  = (i_index != '0) && (LIM_W'(i_index) < LIM_W'(INODE_COUNT));
            in_cnt    = IDX_W'(r_inode_cnt);
        end
    end

    assign alloc_go = !((i_pool == POOL_BLOCK) && blk_empty);

    // counter steps
    assign inode_dec = (r_inode_cnt != '0) ? r_inode_cnt - 1'b1 : r_inode_cnt;
    assign block_dec = (r_block_cnt != '0) ? r_block_cnt - 1'b1 : r_block_cnt;
    assign inode_inc = r_inode_cnt + 1'b1;
    assign block_inc = r_block_cnt + 1'b1;
    assign cur_cnt   = r_pool ? IDX_W'(r_block_cnt) : IDX_W'(r_inode_cnt);

    // search unit on the word just read
    assign cur    = r_valid[r_row] ? i_rdata : '0;
    assign tail   = r_pool ? BLOCK_TAIL : INODE_TAIL;
    assign masked = cur
                  | ((r_row == r_first_row) ? below_mask(r_off) : '0)
                  | ((r_row == r_last_row) ? tail : '0);
    assign lz        = lowest_zero(masked);
    assign wip       = r_row - (r_pool ? MAP_AW'(INODE_WORDS) : '0);
    assign grant_idx = IDX_W'({wip, lz.pos});
    assign bit_set   = cur[r_off];

    // memory requests
    always_comb begin
        o_ram = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ram.raddr = (i_func == FN_ALLOC) ? start_row : idx_row;
                o_ram.re    = accept && ((i_func == FN_ALLOC) ? alloc_go : in_range);
            end
            S_EVAL: begin
                o_ram.waddr = r_row;
                o_ram.raddr = r_row + 1'b1;
                if (r_func == FN_FREE) begin
                    o_ram.we    = bit_set;
                    o_ram.wdata = cur & ~(t_word'(1) << r_off);
                end else begin
                    o_ram.we    = lz.found;
                    o_ram.wdata = cur | (t_word'(1) << lz.pos);
                    o_ram.re    = !lz.found && (r_row != r_last_row);
                end
            end
            S_PUSH: begin
                o_ram = '0;
            end
            default: begin
                o_ram = '0;
            end
        endcase
    end

    assign o_res_valid = (r_state == S_PUSH);
    assign o_res       = r_res;

    // sequencer, counters, valid bits and data start register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_inode_cnt  <= INODE_CNT_W'(INODE_COUNT - 1);
            r_block_cnt  <= BLOCK_CNT_W'(BLOCK_CNT_RESET);
            r_data_start <= DS_W'(DS_RESET);
        end else begin
            // data start write clears the block rows
            if (i_cfg_we) begin
                r_data_start <= i_cfg_data;
                r_block_cnt  <= blk_reload;
                for (int r = INODE_WORDS; r < MAP_WORDS; r++) begin
                    r_valid[r] <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func      <= i_func;
                        r_pool      <= i_pool;
                        r_first_row <= start_row;
                        r_last_row  <= (i_pool == POOL_BLOCK) ? MAP_AW'(MAP_WORDS - 1)
                                                              : MAP_AW'(INODE_WORDS - 1);
                        if (i_func == FN_ALLOC) begin
                            if (alloc_go) begin
                                r_row   <= start_row;
                                r_off   <= start_off;
                                r_state <= S_EVAL;
                            end else begin
                                r_res   <= '{granted_index: '0, status: ST_FULL,
                                             free_count: in_cnt};
                                r_state <= S_PUSH;
                            end
                        end else begin
                            if (in_range) begin
                                r_row   <= idx_row;
                                r_off   <= i_index[WORD_AW-1:0];
                                r_state <= S_EVAL;
                            end else begin
                                r_res   <= '{granted_index: '0, status: ST_IGNORED,
                                             free_count: in_cnt};
                                r_state <= S_PUSH;
                            end
                        end
                    end
                end
                S_EVAL: begin
                    if (r_func == FN_FREE) begin
                        if (bit_set) begin
                            if (r_pool == POOL_BLOCK) begin
                                r_block_cnt <= block_inc;
                                r_res <= '{granted_index: '0, status: ST_OK,
                                           free_count: IDX_W'(block_inc)};
                            end else begin
                                r_inode_cnt <= inode_inc;
                                r_res <= '{granted_index: '0, status: ST_OK,
                                           free_count: IDX_W'(inode_inc)};
                            end
                        end else begin
                            r_res <= '{granted_index: '0, status: ST_IGNORED,
                                       free_count: cur_cnt};
                        end
                        r_state <= S_PUSH;
                    end else if (lz.found) begin
                        r_valid[r_row] <= 1'b1;
                        if (r_pool == POOL_BLOCK) begin
                            r_block_cnt <= block_dec;
                            r_res <= '{granted_index: grant_idx, status: ST_OK,
                                       free_count: IDX_W'(block_dec)};
                        end else begin
                            r_inode_cnt <= inode_dec;
                            r_res <= '{granted_index: grant_idx, status: ST_OK,
                                       free_count: IDX_W'(inode_dec)};
                        end
                        r_state <= S_PUSH;
                    end else if (r_row == r_last_row) begin
                        r_res   <= '{granted_index: '0, status: ST_FULL, free_count: cur_cnt};
                        r_state <= S_PUSH;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sim/bitmap_first_fit_allocator_tb.sv]
// self-checking testbench for the first-fit inode and block bitmap allocator
// depends on bffa_pkg and the bitmap_first_fit_allocator top level
`timescale 1ns / 1ps

module bitmap_first_fit_allocator_tb;
    import bffa_pkg::*;

    // shadow of both pools, predicts each grant beat and checks it on arrival
    class alloc_scoreboard;
        bit               inode_used [INODE_COUNT];
        bit               block_used [BLOCK_COUNT];
        int               inode_free;
        int               block_free;
        logic [DS_W-1:0]  data_start;
        t_result          pending_grants [$];
        int               mismatches;

        function int first_block();
            return (data_start == '0) ? 1 : int'(data_start);
        endfunction

        // a data_start write empties the block map and resizes its range
        function void write_data_start(logic [DS_W-1:0] value);
            data_start = value;
            foreach (block_used[i]) block_used[i] = 1'b0;
            block_free = (first_block() < BLOCK_COUNT) ? BLOCK_COUNT - first_block() : 0;
        endfunction

        function void reset_state();
            foreach (inode_used[i]) inode_used[i] = 1'b0;
            inode_free = INODE_COUNT - 1;
            mismatches = 0;
            pending_grants.delete();
            write_data_start(DS_W'(DS_RESET));
        endfunction

        function bit is_used(logic pool, int i);
            return (pool == POOL_INODE) ? inode_used[i] : block_used[i];
        endfunction

        function void mark(logic pool, int i, bit value);
            if (pool == POOL_INODE) begin
                inode_used[i] = value;
            end else begin
                block_used[i] = value;
            end
        endfunction

        function int range_lo(logic pool);
            return (pool == POOL_INODE) ? 1 : first_block();
        endfunction

        function int range_hi(logic pool);
            return (pool == POOL_INODE) ? INODE_COUNT : BLOCK_COUNT;
        endfunction

        // random entry that is currently in use, or any in-range one if none is
        function logic [IDX_W-1:0] used_index(logic pool);
            int lo;
            int span;
            int start;
            int j;
            lo    = range_lo(pool);
            span  = range_hi(pool) - lo;
            start = $urandom_range(span - 1);
            for (int k = 0; k < span; k++) begin
                j = lo + (start + k) % span;
                if (is_used(pool, j)) return IDX_W'(j);
            end
            return IDX_W'(lo + start);
        endfunction

        // accepted request beat: update the shadow pools and queue the grant
        function void note_request(logic func, logic pool, logic [IDX_W-1:0] idx);
            int      lo;
            int      hi;
            int      cnt;
            t_result r;
            lo  = range_lo(pool);
            hi  = range_hi(pool);
            cnt = (pool == POOL_INODE) ? inode_free : block_free;
            r   = '0;
            if (func == FN_ALLOC) begin
                r.status = ST_FULL;
                for (int i = lo; i < hi; i++) begin
                    if (!is_used(pool, i)) begin
                        mark(pool, i, 1'b1);
                        if (cnt > 0) cnt--;
                        r.granted_index = IDX_W'(i);
                        r.status        = ST_OK;
                        break;
                    end
                end
            end else begin
                if (int'(idx) >= lo && int'(idx) < hi && is_used(pool, int'(idx))) begin
                    mark(pool, int'(idx), 1'b0);
                    cnt++;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_IGNORED;
                end
            end
            if (pool == POOL_INODE) begin
                inode_free = cnt;
            end else begin
                block_free = cnt;
            end
            r.free_count = IDX_W'(cnt);
            pending_grants.push_back(r);
        endfunction

        // result beat: compare against the oldest predicted grant
        function void check_grant(logic [IDX_W-1:0] granted, logic [STATUS_W-1:0] status,
                                  logic [IDX_W-1:0] count);
            t_result e;
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result beat: index %0d status %0d count %0d",
                         $time, granted, status, count);
                mismatches++;
                return;
            end
            e = pending_grants.pop_front();
            if (granted !== e.granted_index) begin
                $display("%0t: granted_index mismatch: expected %0d actual %0d",
                         $time, e.granted_index, granted);
                mismatches++;
            end
            if (status !== e.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, e.status, status);
                mismatches++;
            end
            if (count !== e.free_count) begin
                $display("%0t: free_count mismatch: expected %0d actual %0d",
                         $time, e.free_count, count);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [DS_W-1:0]     i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_func;
    logic                i_pool;
    logic [IDX_W-1:0]    i_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [IDX_W-1:0]    o_granted_index;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_free_count;

    int send_idle_pct;
    int recv_stall_pct;

    alloc_scoreboard pools;

    bitmap_first_fit_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_pool          (i_pool),
        .i_index         (i_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // beat monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pools.note_request(i_func, i_pool, i_index);
            end
            if (o_out_valid && i_out_ready) begin
                pools.check_grant(o_granted_index, o_status, o_free_count);
            end
        end
    end

    // one request beat, with random idle cycles ahead of it
    task automatic send_request(logic func, logic pool, logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_pool     <= pool;
        i_index    <= idx;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait for every grant to come back
    task automatic drain_grants();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pools.pending_grants.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_data_start(logic [DS_W-1:0] value);
        drain_grants();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        pools.write_data_start(value);
    endtask

    // random request: frees mostly hit used entries, some miss or fall out of range
    task automatic random_request(int alloc_pct, int block_pct);
        logic             func;
        logic             pool;
        logic [IDX_W-1:0] idx;
        int               pick;
        func = ($urandom_range(99) < alloc_pct) ? FN_ALLOC : FN_FREE;
        pool = ($urandom_range(99) < block_pct) ? POOL_BLOCK : POOL_INODE;
        idx  = IDX_W'($urandom);
        pick = $urandom_range(99);
        if (func == FN_FREE) begin
            if (pick < 70) begin
                idx = pools.used_index(pool);
            end else if (pick < 85) begin
                idx = IDX_W'($urandom_range(pools.range_hi(pool) - 1, pools.range_lo(pool)));
            end
        end
        send_request(func, pool, idx);
    endtask

    task automatic run_phase(logic [DS_W-1:0] ds, int idle_pct, int stall_pct, int items,
                             int alloc_pct, int block_pct);
        set_data_start(ds);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) random_request(alloc_pct, block_pct);
    endtask

    initial begin
        pools = new();
        pools.reset_state();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = FN_ALLOC;
        i_pool         = POOL_INODE;
        i_index        = '0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset start of 100: lowest grants, double free, out-of-range frees
        send_request(FN_ALLOC, POOL_INODE, '1);
        send_request(FN_ALLOC, POOL_BLOCK, '0);
        send_request(FN_ALLOC, POOL_INODE, '0);
        send_request(FN_FREE,  POOL_INODE, IDX_W'(1));
        send_request(FN_FREE,  POOL_INODE, IDX_W'(1));
        send_request(FN_FREE,  POOL_INODE, IDX_W'(0));
        send_request(FN_FREE,  POOL_INODE, IDX_W'(INODE_COUNT));
        send_request(FN_FREE,  POOL_INODE, '1);
        send_request(FN_ALLOC, POOL_INODE, '0);
        send_request(FN_FREE,  POOL_BLOCK, IDX_W'(DS_RESET - 1));
        send_request(FN_FREE,  POOL_BLOCK, IDX_W'(0));
        send_request(FN_FREE,  POOL_BLOCK, '1);
        send_request(FN_FREE,  POOL_BLOCK, IDX_W'(DS_RESET));

        // start at the last block: a one-entry pool that fills at once
        set_data_start('1);
        send_request(FN_ALLOC, POOL_BLOCK, '0);
        send_request(FN_ALLOC, POOL_BLOCK, '0);
        send_request(FN_FREE,  POOL_BLOCK, '1);
        send_request(FN_FREE,  POOL_BLOCK, IDX_W'(BLOCK_COUNT - 2));
        send_request(FN_ALLOC, POOL_BLOCK, '0);

        // zero start behaves as a start of one
        set_data_start('0);
        send_request(FN_ALLOC, POOL_BLOCK, '0);
        send_request(FN_FREE,  POOL_BLOCK, IDX_W'(0));
        send_request(FN_ALLOC, POOL_BLOCK, '0);

        // random phases: widest range, small block pool, inode fill, then drain
        run_phase(DS_W'(1),    0,  0,  150, 70, 30);
        run_phase(DS_W'(1990), 46, 0,  200, 80, 50);
        run_phase('1,          0,  46, 250, 90, 10);
        run_phase(DS_W'($urandom_range(BLOCK_COUNT - 1, 1)), 20, 20, 250, 35, 50);

        drain_grants();
        repeat (80) @(posedge i_clk);
        if (pools.mismatches == 0 && pools.pending_grants.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/bffa_pkg.sv
hdl/bffa_ram.sv
hdl/bffa_ctrl.sv
hdl/bitmap_first_fit_allocator.sv
sim/bitmap_first_fit_allocator_tb.sv
